// ----- rtl/mewd_pkg.sv -----
// Package of the MIME encoded-word decoder: parse phases, step actions,
// character constants and the small character classifiers. No dependencies.
package mewd_pkg;

	// Parse phase of the candidate word scanner.
	typedef enum logic [2:0] {
		PH_PLAIN   = 3'd0,
		PH_EQ      = 3'd1,
		PH_CHARSET = 3'd2,
		PH_ENC_Q   = 3'd3,
		PH_ENC     = 3'd4,
		PH_TEXT    = 3'd5,
		PH_TEXT_Q  = 3'd6
	} phase_t;

	// What one evaluation of an input byte does.
	typedef enum logic [2:0] {
		ACT_APPEND  = 3'd0,
		ACT_FAIL    = 3'd1,
		ACT_PUT     = 3'd2,
		ACT_RESTART = 3'd3,
		ACT_FINISH  = 3'd4,
		ACT_EOT     = 3'd5
	} act_t;

	// What follows a buffer drain.
	typedef enum logic [1:0] {
		POST_REPROC  = 2'd0,
		POST_DONE    = 2'd1,
		POST_RESTART = 2'd2,
		POST_EOT     = 2'd3
	} post_t;

	localparam int unsigned CFG_W = 16;
	localparam logic [7:0] CH_EQ = 8'h3d;
	localparam logic [7:0] CH_QM = 8'h3f;
	localparam logic [7:0] CH_US = 8'h5f;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;

	// Linear whitespace: space, tab, CR, LF.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
	endfunction

	// Charset token character: printable and not a special.
	function automatic logic is_token(input logic [7:0] c);
		logic r;
		r = (c > CH_SP) && (c < CH_DEL);
		case (c) inside
			8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h22,
			8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h2e, 8'h3d: r = 1'b0;
			default: r = r;
		endcase
		return r;
	endfunction

	// Hex digit value; anything else counts as zero.
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
		else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
		else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
		return t[3:0];
	endfunction

	// Base64 digit value; anything else counts as zero.
	function automatic logic [5:0] b64_digit(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h41 && c <= 8'h5a) t = c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7a) t = c - 8'h47;
		else if (c >= 8'h30 && c <= 8'h39) t = c + 8'h04;
		else if (c == 8'h2b) t = 8'd62;
		else if (c == 8'h2f) t = 8'd63;
		return t[5:0];
	endfunction

endpackage

// ----- rtl/mewd_ifs.sv -----
// Handshake channel interfaces of the MIME encoded-word decoder.
// Text input, result output and the configuration write channel; no dependencies.
interface mewd_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;
	modport source(output valid, in_byte, end_of_text, input ready);
	modport sink(input valid, in_byte, end_of_text, output ready);
endinterface

interface mewd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last_of_text;
	modport source(output valid, out_byte, has_byte, last_of_text, input ready);
	modport sink(input valid, out_byte, has_byte, last_of_text, output ready);
endinterface

interface mewd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_out_len;
	modport source(output valid, max_out_len, input ready);
	modport sink(input valid, max_out_len, output ready);
endinterface

// ----- rtl/mewd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mewd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/mime_encoded_word_decoder_unit.sv -----
// Top level of the MIME encoded-word decoder: scanner, decoder and drain sequencer.
// Depends on mewd_pkg, the channel interfaces in mewd_ifs.sv and mewd_ram.
//
//  channel  | dir | payload                            | accepted when
//  text     | in  | in_byte, end_of_text               | text.valid && text.ready
//  result   | out | out_byte, has_byte, last_of_text   | result.valid && result.ready
//  cfg      | in  | max_out_len                        | cfg.valid && cfg.ready
//
// A byte that is only held is accepted in ST_IDLE and evaluated in ST_PROC; a byte
// passed straight through also passes ST_PUTC to load the result register.
// Draining the pending or decoded memory reads each byte in ST_RD and takes it in
// ST_CAP, as the buffer RAM read is registered; the drain ends in ST_POST, a restart
// rewrites the =? prefix in ST_FIXE and ST_FIXQ, and a re-evaluation re-enters ST_PROC.
// Reset clears all control state; buffer memories need no clearing.
// A stalled result holds the sequencer; new text is taken only when it is idle.
module mime_encoded_word_decoder_unit
	import mewd_pkg::*;
#(
	parameter int unsigned WORD_MAX = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	mewd_text_if.sink       text,
	mewd_result_if.source   result,
	mewd_cfg_if.sink        cfg
);
	localparam int unsigned AW = $clog2(WORD_MAX);
	localparam int unsigned CW = $clog2(WORD_MAX + 1);
	localparam logic [CW-1:0] WM_C = CW'(WORD_MAX);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_PROC = 9'b000000010,
		ST_RD   = 9'b000000100,
		ST_CAP  = 9'b000001000,
		ST_PUTC = 9'b000010000,
		ST_POST = 9'b000100000,
		ST_FIXE = 9'b001000000,
		ST_FIXQ = 9'b010000000,
		ST_TERM = 9'b100000000
	} state_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     dec_cnt_q;
	logic [23:0]       acc_q;
	logic [1:0]        dc_q;
	logic              seen_q;
	logic [15:0]       emitted_q;
	logic [15:0]       max_q;
	logic              enc_b_q;
	logic              stop_q;
	logic              last_eq_q;
	logic              restart_ok_q;
	logic [7:0]        byte_q;
	logic              eot_q;
	logic [CW-1:0]     len_q;
	logic [CW-1:0]     idx_q;
	logic              src_dec_q;
	post_t             post_q;
	logic              any_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_has_q;
	logic              out_last_q;

	// Evaluation of the held byte.
	act_t              act;
	phase_t            nphase;
	logic              do_dec;
	logic              set_enc;
	logic              start_word;
	logic [CW-1:0]     ncount;
	logic              ovf;

	// Decoder step.
	logic [23:0]       nacc;
	logic [1:0]        ndc;
	logic              nstop;
	logic              dpush;
	logic [7:0]        dbyte;
	logic              fpush;
	logic              dec_room;

	// Output and memory control.
	logic [15:0]       limit;
	logic              put_ok;
	logic              out_free;
	logic              out_load;
	logic              p_we;
	logic [AW-1:0]     p_waddr;
	logic [7:0]        p_wdata;
	logic              d_we;
	logic [7:0]        d_wdata;
	logic              rd_en;
	logic [7:0]        p_rdata;
	logic [7:0]        d_rdata;
	logic [7:0]        rdata;

	assign text.ready   = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.out_byte     = out_byte_q;
	assign result.has_byte     = out_has_q;
	assign result.last_of_text = out_last_q;

	assign limit    = (max_q == 16'd0) ? 16'd0 : max_q - 16'd1;
	assign put_ok   = emitted_q < limit;
	assign out_free = !out_valid_q || result.ready;
	assign ncount   = count_q + CW'(1);
	assign ovf      = (ncount == WM_C);
	assign dec_room = dec_cnt_q < WM_C;
	assign rdata    = src_dec_q ? d_rdata : p_rdata;

	// The result register takes a new request in this cycle.
	assign out_load = (((state_q == ST_CAP) || (state_q == ST_PUTC)) && put_ok && out_free) ||
	                  ((state_q == ST_TERM) && out_free);

	// Decide what the held byte does in the current phase.
	always_comb begin
		act        = ACT_FAIL;
		nphase     = phase_q;
		do_dec     = 1'b0;
		set_enc    = 1'b0;
		start_word = 1'b0;
		if (eot_q) begin
			act = ACT_EOT;
		end else begin
			unique case (phase_q)
				PH_PLAIN: begin
					if (byte_q == CH_EQ) begin
						act = ACT_APPEND;
						nphase = PH_EQ;
					end else if (seen_q && is_ws(byte_q)) begin
						act = ACT_APPEND;
					end else if (count_q != '0) begin
						act = ACT_FAIL;
					end else begin
						act = ACT_PUT;
					end
				end
				PH_EQ: begin
					if (byte_q == CH_QM) begin
						act = ACT_APPEND;
						nphase = PH_CHARSET;
					end
				end
				PH_CHARSET: begin
					if (is_token(byte_q)) begin
						act = ACT_APPEND;
					end else if (byte_q == CH_QM) begin
						act = ACT_APPEND;
						nphase = PH_ENC_Q;
					end
				end
				PH_ENC_Q: begin
					if (byte_q == 8'h42 || byte_q == 8'h62 || byte_q == 8'h51 ||
					    byte_q == 8'h71) begin
						act = ACT_APPEND;
						nphase = PH_ENC;
						set_enc = 1'b1;
					end
				end
				PH_ENC: begin
					if (byte_q == CH_QM) begin
						act = ACT_APPEND;
						nphase = PH_TEXT;
						start_word = 1'b1;
					end
				end
				PH_TEXT: begin
					if (byte_q == CH_QM) begin
						act = ACT_APPEND;
						nphase = PH_TEXT_Q;
					end else if (byte_q > CH_SP && byte_q < CH_DEL) begin
						act = ACT_APPEND;
						do_dec = 1'b1;
					end
				end
				PH_TEXT_Q: begin
					if (byte_q == CH_EQ) begin
						act = ACT_FINISH;
					end else if (restart_ok_q) begin
						act = ACT_RESTART;
					end
				end
				default: act = ACT_FAIL;
			endcase
		end
	end

	// One step of the base64 or Q decoder on the held byte.
	always_comb begin
		nacc  = acc_q;
		ndc   = dc_q;
		nstop = stop_q;
		dpush = 1'b0;
		dbyte = 8'h00;
		if (enc_b_q) begin
			if (!stop_q) begin
				if (byte_q == CH_EQ) begin
					nstop = 1'b1;
				end else begin
					nacc = {acc_q[17:0], b64_digit(byte_q)};
					ndc  = dc_q + 2'd1;
					dpush = (ndc != 2'd1);
					case (ndc)
						2'd2: dbyte = nacc[11:4];
						2'd3: dbyte = nacc[9:2];
						default: dbyte = nacc[7:0];
					endcase
				end
			end
		end else if (dc_q == 2'd1) begin
			nacc = {16'h0000, hex_digit(byte_q), 4'h0};
			ndc  = 2'd2;
		end else if (dc_q == 2'd2) begin
			dpush = 1'b1;
			dbyte = acc_q[7:0] | {4'h0, hex_digit(byte_q)};
			ndc   = 2'd0;
		end else if (byte_q == CH_EQ) begin
			nacc = 24'h000000;
			ndc  = 2'd1;
		end else begin
			dpush = 1'b1;
			dbyte = (byte_q == CH_US) ? CH_SP : byte_q;
		end
	end

	// A Q word may end inside an escape; its partial byte goes out.
	assign fpush = !enc_b_q && (dc_q != 2'd0);

	// Memory write and read controls.
	always_comb begin
		p_we    = 1'b0;
		p_waddr = count_q[AW-1:0];
		p_wdata = byte_q;
		d_we    = 1'b0;
		d_wdata = dbyte;
		if (state_q == ST_PROC && act == ACT_APPEND) begin
			p_we = 1'b1;
			d_we = do_dec && dpush && dec_room;
		end else if (state_q == ST_PROC && act == ACT_FINISH) begin
			d_we    = fpush && dec_room;
			d_wdata = acc_q[7:0];
		end else if (state_q == ST_FIXE) begin
			p_we    = 1'b1;
			p_waddr = '0;
			p_wdata = CH_EQ;
		end else if (state_q == ST_FIXQ) begin
			p_we    = 1'b1;
			p_waddr = AW'(1);
			p_wdata = CH_QM;
		end
	end

	assign rd_en = (state_q == ST_RD);

	mewd_ram #(.WIDTH(8), .DEPTH(WORD_MAX)) u_pending_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.re    (rd_en && !src_dec_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (p_rdata)
	);

	mewd_ram #(.WIDTH(8), .DEPTH(WORD_MAX)) u_decoded_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (dec_cnt_q[AW-1:0]),
		.wdata (d_wdata),
		.re    (rd_en && src_dec_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (d_rdata)
	);

	// Sequencer, scanner state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_PLAIN;
			count_q      <= '0;
			dec_cnt_q    <= '0;
			acc_q        <= '0;
			dc_q         <= '0;
			seen_q       <= 1'b0;
			emitted_q    <= '0;
			max_q        <= 16'hffff;
			enc_b_q      <= 1'b0;
			stop_q       <= 1'b0;
			last_eq_q    <= 1'b0;
			restart_ok_q <= 1'b0;
			eot_q        <= 1'b0;
			len_q        <= '0;
			idx_q        <= '0;
			src_dec_q    <= 1'b0;
			post_q       <= POST_DONE;
			any_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				max_q <= cfg.max_out_len;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (text.valid) begin
						byte_q  <= text.in_byte;
						eot_q   <= text.end_of_text;
						state_q <= ST_PROC;
					end
				end
				ST_PROC: begin
					idx_q <= '0;
					unique case (act)
						ACT_APPEND: begin
							last_eq_q <= (byte_q == CH_EQ);
							if (phase_q == PH_TEXT && byte_q == CH_QM) begin
								restart_ok_q <= last_eq_q;
							end
							if (set_enc) begin
								enc_b_q <= (byte_q == 8'h42 || byte_q == 8'h62);
							end
							if (start_word) begin
								dec_cnt_q <= '0;
								acc_q     <= '0;
								dc_q      <= '0;
								stop_q    <= 1'b0;
							end
							if (do_dec) begin
								acc_q  <= nacc;
								dc_q   <= ndc;
								stop_q <= nstop;
								if (dpush && dec_room) begin
									dec_cnt_q <= dec_cnt_q + CW'(1);
								end
							end
							if (ovf) begin
								len_q     <= ncount;
								src_dec_q <= 1'b0;
								post_q    <= POST_DONE;
								count_q   <= '0;
								seen_q    <= 1'b0;
								phase_q   <= PH_PLAIN;
								state_q   <= ST_RD;
							end else begin
								count_q <= ncount;
								phase_q <= nphase;
								state_q <= ST_IDLE;
							end
						end
						ACT_FAIL: begin
							len_q     <= count_q;
							src_dec_q <= 1'b0;
							post_q    <= POST_REPROC;
							count_q   <= '0;
							seen_q    <= 1'b0;
							phase_q   <= PH_PLAIN;
							state_q   <= (count_q == '0) ? ST_POST : ST_RD;
						end
						ACT_PUT: begin
							seen_q  <= 1'b0;
							state_q <= ST_PUTC;
						end
						ACT_RESTART: begin
							len_q     <= count_q - CW'(2);
							src_dec_q <= 1'b0;
							post_q    <= POST_RESTART;
							count_q   <= CW'(2);
							seen_q    <= 1'b0;
							last_eq_q <= 1'b0;
							phase_q   <= PH_CHARSET;
							state_q   <= (count_q == CW'(2)) ? ST_POST : ST_RD;
						end
						ACT_FINISH: begin
							len_q     <= dec_cnt_q + CW'(fpush && dec_room);
							src_dec_q <= 1'b1;
							post_q    <= POST_DONE;
							count_q   <= '0;
							dec_cnt_q <= '0;
							acc_q     <= '0;
							dc_q      <= '0;
							seen_q    <= 1'b1;
							phase_q   <= PH_PLAIN;
							state_q   <= (dec_cnt_q == '0 && !(fpush && dec_room)) ?
							             ST_POST : ST_RD;
						end
						ACT_EOT: begin
							len_q     <= count_q;
							src_dec_q <= 1'b0;
							post_q    <= POST_EOT;
							any_q     <= 1'b0;
							state_q   <= (count_q == '0) ? ST_POST : ST_RD;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_RD: begin
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					if (!put_ok || out_free) begin
						if (put_ok) begin
							out_valid_q <= 1'b1;
							out_byte_q  <= rdata;
							out_has_q   <= 1'b1;
							out_last_q  <= (post_q == POST_EOT) &&
							               ((idx_q + CW'(1) == len_q) ||
							                (emitted_q + 16'd1 == limit));
							emitted_q   <= emitted_q + 16'd1;
							any_q       <= 1'b1;
						end
						idx_q   <= idx_q + CW'(1);
						state_q <= (idx_q + CW'(1) == len_q) ? ST_POST : ST_RD;
					end
				end
				ST_PUTC: begin
					if (!put_ok) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= byte_q;
						out_has_q   <= 1'b1;
						out_last_q  <= 1'b0;
						emitted_q   <= emitted_q + 16'd1;
						state_q     <= ST_IDLE;
					end
				end
				ST_POST: begin
					unique case (post_q)
						POST_REPROC:  state_q <= ST_PROC;
						POST_RESTART: state_q <= ST_FIXE;
						POST_DONE:    state_q <= ST_IDLE;
						POST_EOT: begin
							if (any_q) begin
								phase_q   <= PH_PLAIN;
								count_q   <= '0;
								dec_cnt_q <= '0;
								acc_q     <= '0;
								dc_q      <= '0;
								seen_q    <= 1'b0;
								emitted_q <= '0;
								enc_b_q   <= 1'b0;
								stop_q    <= 1'b0;
								state_q   <= ST_IDLE;
							end else begin
								state_q <= ST_TERM;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_FIXE: begin
					state_q <= ST_FIXQ;
				end
				ST_FIXQ: begin
					state_q <= ST_PROC;
				end
				ST_TERM: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= 8'h00;
						out_has_q   <= 1'b0;
						out_last_q  <= 1'b1;
						phase_q     <= PH_PLAIN;
						count_q     <= '0;
						dec_cnt_q   <= '0;
						acc_q       <= '0;
						dc_q        <= '0;
						seen_q      <= 1'b0;
						emitted_q   <= '0;
						enc_b_q     <= 1'b0;
						stop_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
